@@ sv/mrpt_pkg.sv @@
// package: types, codes and constants shared by the miller-rabin round test
package mrpt_pkg;

  localparam int unsigned FIELD_W   = 64;
  localparam int unsigned DEF_WIDTH = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] candidate;
    logic [FIELD_W-1:0] random_word;
  } mrpt_in_t;

  typedef struct packed {
    logic               probably_prime;
    logic [FIELD_W-1:0] witness_base;
  } mrpt_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV,
    ST_PINIT,
    ST_PCHK,
    ST_PMACC,
    ST_PSQS,
    ST_PSQ,
    ST_SINIT,
    ST_SCHK,
    ST_SWAIT,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STRIP,
    OP_DIV,
    OP_PINIT,
    OP_MUL_ACC,
    OP_WB_ACC,
    OP_MUL_BASE,
    OP_WB_BASE,
    OP_SINIT,
    OP_MUL_X,
    OP_WB_X,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e op;
  } mrpt_cmd_t;

  typedef struct packed {
    logic trivial;
    logic s_odd;
    logic div_last;
    logic pe_zero;
    logic pe_odd;
    logic mul_done;
    logic sq_more;
    logic out_free;
  } mrpt_sts_t;

endpackage

@@ sv/mrpt_mulmod.sv @@
// iterative shift-add modular multiplier, one multiplier bit per cycle
module mrpt_mulmod import mrpt_pkg::*; #(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] n_i,
  output logic             done_o,
  output logic [WIDTH-1:0] res_o
);

  logic             busy_q, busy_d;
  logic [WIDTH-1:0] acc_q, acc_d, b_q, b_d, y_q, y_d;

  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] n);
    logic [WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, n}) begin
      sum = sum - {1'b0, n};
    end
    return sum[WIDTH-1:0];
  endfunction

  assign done_o = busy_q && (y_q == '0);
  assign res_o  = acc_q;

  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    b_d    = b_q;
    y_d    = y_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      b_d    = x_i;
      y_d    = y_i;
    end else if (busy_q) begin
      if (y_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (y_q[0]) begin
          acc_d = add_mod(acc_q, b_q, n_i);
        end
        b_d = add_mod(b_q, b_q, n_i);
        y_d = y_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    y_q   <= y_d;
  end

endmodule

@@ sv/mrpt_datapath.sv @@
// datapath: operand registers, remainder steps, modular multiplier and result register
module mrpt_datapath import mrpt_pkg::*; #(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mrpt_in_t  in_data_i,
  input  mrpt_cmd_t cmd_i,
  output mrpt_sts_t sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output mrpt_out_t out_data_o
);

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] n_q, nm1_q, s_q, rsh_q, rem_q, a_q;
  logic [WIDTH-1:0] acc_q, base_q, pe_q, x_q, e_q;
  logic [CW-1:0]    cnt_q;
  logic             trivial_q;
  logic             out_valid_q;
  mrpt_out_t        out_q;

  logic [WIDTH-1:0] n_in, r_in;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             mul_start, mul_done;
  logic [WIDTH-1:0] mul_x, mul_y, mul_res;
  logic             trivial_in;

  assign n_in = in_data_i.candidate[WIDTH-1:0];
  assign r_in = in_data_i.random_word[WIDTH-1:0];
  assign trivial_in = (n_in < WIDTH'(2)) || ((n_in != WIDTH'(2)) && !n_in[0]);

  assign shifted = {rem_q, rsh_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, nm1_q};

  always_comb begin
    mul_start = 1'b0;
    mul_x     = acc_q;
    mul_y     = base_q;
    unique case (cmd_i.op)
      OP_MUL_ACC: begin
        mul_start = 1'b1;
      end
      OP_MUL_BASE: begin
        mul_start = 1'b1;
        mul_x     = base_q;
      end
      OP_MUL_X: begin
        mul_start = 1'b1;
        mul_x     = x_q;
        mul_y     = x_q;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  mrpt_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .n_i     (n_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  assign sts_o.trivial  = trivial_q;
  assign sts_o.s_odd    = s_q[0];
  assign sts_o.div_last = (cnt_q == CW'(WIDTH - 1));
  assign sts_o.pe_zero  = (pe_q == '0);
  assign sts_o.pe_odd   = pe_q[0];
  assign sts_o.mul_done = mul_done;
  assign sts_o.sq_more  = (e_q != nm1_q) && (x_q != WIDTH'(1)) && (x_q != nm1_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        n_q       <= n_in;
        nm1_q     <= n_in - WIDTH'(1);
        s_q       <= n_in - WIDTH'(1);
        rsh_q     <= r_in;
        rem_q     <= '0;
        cnt_q     <= '0;
        trivial_q <= trivial_in;
      end
      OP_STRIP: begin
        s_q <= s_q >> 1;
      end
      OP_DIV: begin
        rem_q <= diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
        rsh_q <= rsh_q << 1;
        cnt_q <= cnt_q + CW'(1);
      end
      OP_PINIT: begin
        a_q    <= rem_q + WIDTH'(1);
        base_q <= rem_q + WIDTH'(1);
        acc_q  <= WIDTH'(1);
        pe_q   <= s_q;
      end
      OP_WB_ACC: begin
        acc_q <= mul_res;
      end
      OP_WB_BASE: begin
        base_q <= mul_res;
        pe_q   <= pe_q >> 1;
      end
      OP_SINIT: begin
        x_q <= acc_q;
        e_q <= s_q;
      end
      OP_WB_X: begin
        x_q <= mul_res;
        e_q <= e_q << 1;
      end
      OP_RESULT: begin
        if (trivial_q) begin
          out_q.probably_prime <= 1'b0;
          out_q.witness_base   <= '0;
        end else begin
          out_q.probably_prime <= !((x_q != nm1_q) && !e_q[0]);
          out_q.witness_base   <= FIELD_W'(a_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RESULT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

@@ sv/mrpt_ctrl.sv @@
// controller: state machine that sequences the datapath for one round
module mrpt_ctrl import mrpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mrpt_sts_t sts_i,
  output mrpt_cmd_t cmd_o
);

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (sts_i.trivial) begin
          state_d = ST_DONE;
        end else if (sts_i.s_odd) begin
          state_d = ST_DIV;
        end else begin
          cmd_o.op = OP_STRIP;
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (sts_i.div_last) begin
          state_d = ST_PINIT;
        end
      end
      ST_PINIT: begin
        cmd_o.op = OP_PINIT;
        state_d  = ST_PCHK;
      end
      ST_PCHK: begin
        if (sts_i.pe_zero) begin
          state_d = ST_SINIT;
        end else if (sts_i.pe_odd) begin
          cmd_o.op = OP_MUL_ACC;
          state_d  = ST_PMACC;
        end else begin
          cmd_o.op = OP_MUL_BASE;
          state_d  = ST_PSQ;
        end
      end
      ST_PMACC: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_WB_ACC;
          state_d  = ST_PSQS;
        end
      end
      ST_PSQS: begin
        cmd_o.op = OP_MUL_BASE;
        state_d  = ST_PSQ;
      end
      ST_PSQ: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_WB_BASE;
          state_d  = ST_PCHK;
        end
      end
      ST_SINIT: begin
        cmd_o.op = OP_SINIT;
        state_d  = ST_SCHK;
      end
      ST_SCHK: begin
        if (sts_i.sq_more) begin
          cmd_o.op = OP_MUL_X;
          state_d  = ST_SWAIT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SWAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_WB_X;
          state_d  = ST_SCHK;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_RESULT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/miller_rabin_prime_test_top.sv @@
// top level: one miller-rabin round on a candidate with a base drawn from a random word
//
// Each accepted transaction runs one Miller-Rabin round on the low WIDTH bits of candidate.
// Trivial rejections (below 2, or even and not 2) skip the arithmetic and finish
// with witness_base 0. Otherwise factors of two are stripped from candidate-1, the random
// word is reduced to a base, and one shared shift-add modular multiplier that handles one
// multiplier bit per cycle runs up to 2*WIDTH exponent multiplies and up to WIDTH further
// squarings. One transaction is worked on at a time; the next is accepted once the
// previous result sits in the output register.
module miller_rabin_prime_test_top import mrpt_pkg::*; #(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mrpt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mrpt_out_t out_data_o
);

  mrpt_cmd_t cmd;
  mrpt_sts_t sts;

  mrpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrpt_datapath #(.WIDTH(WIDTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
